@@ sv/lfurf_pkg.sv @@
// Shared constants and controller/datapath interface types for the LFU cache.
`timescale 1ns / 1ps
`default_nettype none

package lfurf_pkg;

    localparam int LFURF_ENTRIES   = 64;
    localparam int LFURF_FREQ_BITS = 16;

    localparam int CMD_W     = 2;
    localparam int ID_W      = 64;
    localparam int CAP_W     = 7;
    localparam int QT_W      = 64;
    localparam int CNT_OUT_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;       // write an empty slot at the sweep address
        logic load;      // capture the input item, restart the scan
        logic rd;        // read the slot at the sweep address
        logic decide;    // settle eviction and the insert slot
        logic wr_a;      // first write of the update
        logic wr_b;      // insert after a separate eviction
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic addr_last; // sweep address is on the last slot
        logic two_wr;    // eviction and insert hit different slots
        logic out_free;  // output register can take a result
    } t_dp_sts;

endpackage

`default_nettype wire

@@ sv/lfu_replacement_fifo_ties.sv @@
// Top level of the LFU object cache with first-in order among equal counts.
//
// Input channel: i_in_valid / o_in_stall with i_cmd and i_obj_id; a transfer
// happens on a rising edge with valid high and stall low. Output channel:
// o_out_valid / i_out_stall with o_hit, o_count_now, o_evicted_valid and
// o_evicted_id; one result per input item, in order.
// Capacity is written on i_cfg_capacity when i_cfg_valid and o_cfg_ready are
// high; o_cfg_ready is always high. Write it only while the block is idle.
// Each item sweeps the slot memory once, one slot per cycle through its
// single read port, then updates it through its write port: the last read
// word is compared, eviction and the insert slot are settled, and the first
// write follows, with a second write when an eviction and an insert land in
// different slots. The result then goes into the output register, and the
// next item is taken only after that load.
// Reset (synchronous, active low) starts a clearing pass that empties every
// slot; o_in_stall stays high until it ends.
// A stalled result is held in the output register; the next item is still
// taken and processed, and its result waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module lfu_replacement_fifo_ties #(
    parameter int ENTRIES   = lfurf_pkg::LFURF_ENTRIES,
    parameter int FREQ_BITS = lfurf_pkg::LFURF_FREQ_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [lfurf_pkg::CMD_W-1:0]       i_cmd,
    input  wire [lfurf_pkg::ID_W-1:0]        i_obj_id,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_hit,
    output logic [lfurf_pkg::CNT_OUT_W-1:0]  o_count_now,
    output logic                             o_evicted_valid,
    output logic [lfurf_pkg::ID_W-1:0]       o_evicted_id,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [lfurf_pkg::CAP_W-1:0]       i_cfg_capacity
);
    import lfurf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    lfurf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    lfurf_dpath #(
        .ENTRIES   (ENTRIES),
        .FREQ_BITS (FREQ_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_item_cmd      (i_cmd),
        .i_item_id       (i_obj_id),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_count_now     (o_count_now),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id)
    );

endmodule

`default_nettype wire

@@ sv/lfurf_ctrl.sv @@
// Controller state machine that sequences clear, scan, update and result transfer.
`timescale 1ns / 1ps
`default_nettype none

module lfurf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  lfurf_pkg::t_dp_sts   i_sts,
    output lfurf_pkg::t_dp_cmd   o_cmd
);
    import lfurf_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_WR_A   = 3'd5;
    localparam logic [2:0] ST_WR_B   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.addr_last) n_state = ST_DRAIN;
            end
            // last read word is compared here
            ST_DRAIN: n_state = ST_DECIDE;
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_WR_A;
            end
            ST_WR_A: begin
                o_cmd.wr_a = 1'b1;
                n_state    = i_sts.two_wr ? ST_WR_B : ST_DONE;
            end
            ST_WR_B: begin
                o_cmd.wr_b = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ sv/lfurf_dpath.sv @@
// Datapath: slot memory, scan trackers, counters, capacity and output register.
`timescale 1ns / 1ps
`default_nettype none

module lfurf_dpath #(
    parameter int ENTRIES   = lfurf_pkg::LFURF_ENTRIES,
    parameter int FREQ_BITS = lfurf_pkg::LFURF_FREQ_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lfurf_pkg::t_dp_cmd                 i_cmd,
    output lfurf_pkg::t_dp_sts                 o_sts,
    input  wire [lfurf_pkg::CMD_W-1:0]         i_item_cmd,
    input  wire [lfurf_pkg::ID_W-1:0]          i_item_id,
    input  wire                                i_cfg_we,
    input  wire [lfurf_pkg::CAP_W-1:0]         i_cfg_capacity,
    input  wire                                i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_hit,
    output logic [lfurf_pkg::CNT_OUT_W-1:0]    o_count_now,
    output logic                               o_evicted_valid,
    output logic [lfurf_pkg::ID_W-1:0]         o_evicted_id
);
    import lfurf_pkg::*;

    localparam int IW   = $clog2(ENTRIES);
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int FB   = FREQ_BITS;
    localparam int WW   = 1 + ID_W + FB + QT_W;
    localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;
    localparam int RW   = (FB > CNT_OUT_W) ? FB : CNT_OUT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // slot word: {valid, tag, count, queue time}
    logic [WW-1:0] mem [ENTRIES];
    logic [WW-1:0] r_rd_word;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;

    logic [IW-1:0]    r_addr;
    logic [CAP_W-1:0] r_cap;
    logic [OW-1:0]    r_occ;
    logic [QT_W-1:0]  r_clock;

    logic [CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]  r_id;

    logic          r_hit_fnd;
    logic [IW-1:0] r_hit_idx;
    logic [FB-1:0] r_hit_cnt;
    logic          r_free_fnd;
    logic [IW-1:0] r_free_idx;
    logic          r_vic_fnd;
    logic [IW-1:0] r_vic_idx;
    logic [FB-1:0] r_vic_cnt;
    logic [QT_W-1:0] r_vic_qt;
    logic [ID_W-1:0] r_vic_tag;

    logic          r_evict;
    logic          r_two;
    logic [IW-1:0] r_dst;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [CNT_OUT_W-1:0] r_out_cnt;
    logic                 r_out_ev;
    logic [ID_W-1:0]      r_out_ev_id;

    logic            rd_valid;
    logic [ID_W-1:0] rd_tag;
    logic [FB-1:0]   rd_cnt;
    logic [QT_W-1:0] rd_qt;
    logic            vic_better;

    logic [CMPW-1:0] cap_x;
    logic [CMPW-1:0] eff_cap;
    logic            full;
    logic            evict_now;
    logic            vic_is_dst;

    logic [FB-1:0]   inc_cnt;
    logic [FB-1:0]   res_cnt;
    logic [RW-1:0]   res_ext;
    logic [CNT_OUT_W-1:0] res_rep;
    logic            res_ev;
    logic            clk_adv;

    logic [WW-1:0] upd_word;
    logic [WW-1:0] ins_word;

    assign rd_valid = r_rd_word[WW-1];
    assign rd_tag   = r_rd_word[WW-2 -: ID_W];
    assign rd_cnt   = r_rd_word[QT_W +: FB];
    assign rd_qt    = r_rd_word[QT_W-1:0];

    // least count first, earliest queue time among equal counts
    assign vic_better = rd_valid && (!r_vic_fnd || (rd_cnt < r_vic_cnt) ||
                        ((rd_cnt == r_vic_cnt) && (rd_qt < r_vic_qt)));

    always_comb begin
        cap_x = CMPW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_x > CMPW'(ENTRIES)) begin
            eff_cap = CMPW'(ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
    end

    assign full      = (CMPW'(r_occ) >= eff_cap);
    assign evict_now = (r_cmd == CMD_ACCESS) && !r_hit_fnd && full && r_vic_fnd;
    // the freed victim slot is reused when it is the lowest empty slot
    assign vic_is_dst = !r_free_fnd || (r_vic_idx < r_free_idx);

    assign inc_cnt  = (r_hit_cnt == {FB{1'b1}}) ? r_hit_cnt : (r_hit_cnt + FB'(1));
    assign upd_word = {1'b1, r_id, inc_cnt, r_clock};
    assign ins_word = {1'b1, r_id, FB'(1), r_clock};

    always_comb begin
        case (r_cmd)
            CMD_ACCESS: res_cnt = r_hit_fnd ? inc_cnt : FB'(1);
            CMD_REMOVE: res_cnt = '0;
            default:    res_cnt = r_hit_fnd ? r_hit_cnt : '0;
        endcase
    end

    assign res_ext = RW'(res_cnt);
    assign res_rep = (res_ext > RW'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                        : res_ext[CNT_OUT_W-1:0];
    assign res_ev  = (r_cmd == CMD_ACCESS) && !r_hit_fnd && r_evict;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        if (i_cmd.clr) begin
            mem_we = 1'b1;
        end else if (i_cmd.wr_a) begin
            case (r_cmd)
                CMD_ACCESS: begin
                    mem_we = 1'b1;
                    if (r_hit_fnd) begin
                        mem_wa = r_hit_idx;
                        mem_wd = upd_word;
                    end else if (r_two) begin
                        mem_wa = r_vic_idx;  // drop the victim, insert follows
                    end else begin
                        mem_wa = r_dst;
                        mem_wd = ins_word;
                    end
                end
                CMD_REMOVE: begin
                    mem_we = r_hit_fnd;
                    mem_wa = r_hit_idx;
                end
                default: mem_we = 1'b0;
            endcase
        end else if (i_cmd.wr_b) begin
            mem_we = 1'b1;
            mem_wa = r_dst;
            mem_wd = ins_word;
        end
    end

    assign clk_adv = (i_cmd.wr_a && (r_cmd == CMD_ACCESS) && (r_hit_fnd || !r_two)) ||
                     i_cmd.wr_b;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd_word <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_clock     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cfg_we) r_cap <= i_cfg_capacity;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.clr || i_cmd.rd) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : (r_addr + IW'(1));
            end
            if (clk_adv) r_clock <= r_clock + QT_W'(1);
            if (i_cmd.wr_a) begin
                if ((r_cmd == CMD_ACCESS) && !r_hit_fnd && !r_evict) begin
                    r_occ <= r_occ + OW'(1);
                end else if ((r_cmd == CMD_REMOVE) && r_hit_fnd) begin
                    r_occ <= r_occ - OW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (i_cmd.load) begin
            r_cmd      <= i_item_cmd;
            r_id       <= i_item_id;
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_vic_fnd  <= 1'b0;
        end else if (r_rd_vld) begin
            if (rd_valid && (rd_tag == r_id) && !r_hit_fnd) begin
                r_hit_fnd <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_cnt <= rd_cnt;
            end
            if (!rd_valid && !r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (vic_better) begin
                r_vic_fnd <= 1'b1;
                r_vic_idx <= r_rd_idx;
                r_vic_cnt <= rd_cnt;
                r_vic_qt  <= rd_qt;
                r_vic_tag <= rd_tag;
            end
        end
        if (i_cmd.decide) begin
            r_evict <= evict_now;
            r_two   <= evict_now && !vic_is_dst;
            r_dst   <= (evict_now && vic_is_dst) ? r_vic_idx : r_free_idx;
        end
        if (i_cmd.out_load) begin
            r_out_hit   <= r_hit_fnd;
            r_out_cnt   <= res_rep;
            r_out_ev    <= res_ev;
            r_out_ev_id <= res_ev ? r_vic_tag : '0;
        end
    end

    assign o_sts.addr_last = (r_addr == LAST_IDX);
    assign o_sts.two_wr    = r_two;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_count_now     = r_out_cnt;
    assign o_evicted_valid = r_out_ev;
    assign o_evicted_id    = r_out_ev_id;

endmodule

`default_nettype wire
